@@ rtl/bf_pkg.sv @@
// Shared types, item codes and initial subkey constants for the Blowfish engine.
package bf_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_sbox_addr;

    localparam logic [1:0] KIND_LOAD_P = 2'd0;
    localparam logic [1:0] KIND_LOAD_S = 2'd1;
    localparam logic [1:0] KIND_ENC    = 2'd2;
    localparam logic [1:0] KIND_DEC    = 2'd3;

    localparam int SBOX_COUNT = 4;
    localparam int SBOX_DEPTH = 256;
    localparam int PI_COUNT   = 34;

    localparam t_word PI_WORDS [PI_COUNT] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
        32'h9216D5D9, 32'h8979FB1B,
        32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7,
        32'hB8E1AFED, 32'h6A267E96, 32'hBA7C9045, 32'hF12C7F99,
        32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
        32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E
    };

    function automatic t_word round_f(input t_word s0, input t_word s1,
                                      input t_word s2, input t_word s3);
        return ((s0 + s1) ^ s2) + s3;
    endfunction

endpackage

@@ rtl/bf_sbox_ram.sv @@
// One 256-entry S-box memory with a registered read port and a write port.
module bf_sbox_ram (
    input  logic               i_clk,
    input  logic               i_we,
    input  bf_pkg::t_sbox_addr i_waddr,
    input  bf_pkg::t_word      i_wdata,
    input  bf_pkg::t_sbox_addr i_raddr,
    output bf_pkg::t_word      o_rdata
);

    bf_pkg::t_word r_mem [bf_pkg::SBOX_DEPTH];
    bf_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bf_parray.sv @@
// Subkey P-array registers with pi reset values, one round read and the output whitening words.
module bf_parray #(
    parameter int ROUNDS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [9:0]                       i_waddr,
    input  bf_pkg::t_word                    i_wdata,
    input  logic [$clog2(ROUNDS + 2) - 1:0]  i_raddr,
    output bf_pkg::t_word                    o_rdata,
    input  logic                             i_rev,
    output bf_pkg::t_word                    o_fin_l,
    output bf_pkg::t_word                    o_fin_r
);

    localparam int PW = ROUNDS + 2;
    localparam int KW = $clog2(PW);

    bf_pkg::t_word r_p [PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PW; j++) begin
                r_p[j] <= bf_pkg::PI_WORDS[j];
            end
        end else if (i_we && (i_waddr < 10'(PW))) begin
            r_p[i_waddr[KW-1:0]] <= i_wdata;
        end
    end

    assign o_rdata = r_p[i_raddr];
    assign o_fin_l = i_rev ? r_p[0] : r_p[ROUNDS + 1];
    assign o_fin_r = i_rev ? r_p[1] : r_p[ROUNDS];

endmodule

@@ rtl/blowfish_block_crypt.sv @@
// Top level of the Blowfish block engine: item decode, round sequencer and result register.
//
// Usage: one input channel (i_valid / o_stall) carries items of four kinds:
// P-array word load, S-box word load, encrypt block and decrypt block. Loads
// write their word, leave the input free and give no result. An S-box entry must be
// loaded before any block reads it. The output channel (o_valid / i_stall)
// carries one word per encrypt or decrypt item: the two 32-bit halves.
// A block item occupies the engine for ROUNDS Feistel rounds, one round per cycle
// (the last round holds while the output register is not free), set by the loop
// through the four S-box RAMs (registered read) and the round function back to
// the RAM addresses. The result word is in the output register when the last
// round completes. o_stall is high while a block is in flight, so the next item
// is taken only after the block leaves its last round, even while a result
// waits.
// Reset: the P-array returns to the pi constants and all control state clears;
// S-box contents are kept and are undefined after power-up.
// When the receiver stalls, the result word holds, and a following block stops
// in its last round until the output register is free.
module blowfish_block_crypt #(
    parameter int ROUNDS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_kind,
    input  logic [9:0]    i_table_index,
    input  logic [31:0]   i_table_word,
    input  logic [31:0]   i_left_half,
    input  logic [31:0]   i_right_half,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [31:0]   o_out_left,
    output logic [31:0]   o_out_right
);

    localparam int PW = ROUNDS + 2;
    localparam int KW = $clog2(PW);
    localparam int CW = $clog2(ROUNDS);

    logic           r_busy, n_busy;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_rev, n_rev;
    bf_pkg::t_word  r_lx, n_lx;
    bf_pkg::t_word  r_r, n_r;
    logic           r_ovalid, n_ovalid;
    bf_pkg::t_word  r_oleft, n_oleft;
    bf_pkg::t_word  r_oright, n_oright;

    logic           in_acc, is_block, is_rev_in, last, fin_ok;
    logic [CW-1:0]  next_i;
    logic [KW-1:0]  p_raddr;
    bf_pkg::t_word  p_rdata, fin_l, fin_r, f_val, r_new, lx_start, lx_next, lx_addr;
    bf_pkg::t_word  s_rdata [bf_pkg::SBOX_COUNT];

    function automatic logic [KW-1:0] key_index(input logic [CW-1:0] i, input logic rev);
        return rev ? (KW'(ROUNDS + 1) - KW'(i)) : KW'(i);
    endfunction

    assign in_acc    = i_valid && !r_busy;
    assign is_block  = (i_kind == bf_pkg::KIND_ENC) || (i_kind == bf_pkg::KIND_DEC);
    assign is_rev_in = (i_kind == bf_pkg::KIND_DEC);
    assign last      = (r_cnt == CW'(ROUNDS - 1));
    assign fin_ok    = !r_ovalid || !i_stall;
    assign next_i    = last ? '0 : (r_cnt + CW'(1));
    assign p_raddr   = r_busy ? key_index(next_i, r_rev) : key_index('0, is_rev_in);

    assign f_val    = bf_pkg::round_f(s_rdata[0], s_rdata[1], s_rdata[2], s_rdata[3]);
    assign r_new    = r_r ^ f_val;
    assign lx_start = i_left_half ^ p_rdata;
    assign lx_next  = r_new ^ p_rdata;
    assign lx_addr  = !r_busy ? lx_start : (last ? r_lx : lx_next);

    bf_parray #(.ROUNDS(ROUNDS)) u_parray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (in_acc && (i_kind == bf_pkg::KIND_LOAD_P)),
        .i_waddr (i_table_index),
        .i_wdata (i_table_word),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata),
        .i_rev   (r_rev),
        .o_fin_l (fin_l),
        .o_fin_r (fin_r)
    );

    for (genvar b = 0; b < bf_pkg::SBOX_COUNT; b++) begin : g_sbox
        bf_sbox_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (in_acc && (i_kind == bf_pkg::KIND_LOAD_S)
                      && (i_table_index[9:8] == 2'(b))),
            .i_waddr (i_table_index[7:0]),
            .i_wdata (i_table_word),
            .i_raddr (lx_addr[31 - 8 * b -: 8]),
            .o_rdata (s_rdata[b])
        );
    end

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_rev    = r_rev;
        n_lx     = r_lx;
        n_r      = r_r;
        n_ovalid = r_ovalid && i_stall;
        n_oleft  = r_oleft;
        n_oright = r_oright;
        if (!r_busy) begin
            if (in_acc && is_block) begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rev  = is_rev_in;
                n_lx   = lx_start;
                n_r    = i_right_half;
            end
        end else if (!last) begin
            n_cnt = next_i;
            n_lx  = lx_next;
            n_r   = r_lx;
        end else if (fin_ok) begin
            n_busy   = 1'b0;
            n_ovalid = 1'b1;
            n_oleft  = r_lx ^ fin_l;
            n_oright = r_new ^ fin_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_rev    <= n_rev;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lx     <= n_lx;
        r_r      <= n_r;
        r_oleft  <= n_oleft;
        r_oright <= n_oright;
    end

    assign o_stall     = r_busy;
    assign o_valid     = r_ovalid;
    assign o_out_left  = r_oleft;
    assign o_out_right = r_oright;

endmodule

@@ rtl/bf_checker.sv @@
// Port-level checks on the Blowfish engine and the bind that attaches them.
module bf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_left,
    input logic [31:0] o_out_right
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == bf_pkg::KIND_ENC || i_kind == bf_pkg::KIND_DEC) |=> o_stall)
        else $error("block item did not occupy the engine");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_kind == bf_pkg::KIND_LOAD_P || i_kind == bf_pkg::KIND_LOAD_S)
        |=> !o_stall && !$rose(o_valid))
        else $error("load item stalled the input or produced a result");

    a_result_from_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall) && $fell(o_stall))
        else $error("result word appeared without a finishing block");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_left) && $stable(o_out_right))
        else $error("stalled result word changed");

endmodule

bind blowfish_block_crypt bf_checker u_bf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_kind      (i_kind),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_left  (o_out_left),
    .o_out_right (o_out_right)
);
